@@ rtl/sdtt_pkg.sv @@
// sdtt_pkg: shared types, codes and defaults for the sorted deadline timer table
// used by sdtt_cmp, the top level and the testbench, no dependencies of its own
package sdtt_pkg;

  localparam int DEF_TIMER_SLOTS = 32;
  localparam int SLOT_W          = 5;
  localparam int TICK_W          = 32;
  localparam int STATUS_W        = 2;

  typedef enum logic [1:0] {
    FN_INSERT = 2'd0,
    FN_REMOVE = 2'd1,
    FN_UPDATE = 2'd2,
    FN_TICK   = 2'd3
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_ARMED = 2'd1,
    ST_ARMED     = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_LAST,
    S_EMIT
  } state_t;

  // one stored timer entry: deadline then arming stamp, so a plain compare orders them
  typedef struct packed {
    logic [TICK_W-1:0] deadline;
    logic [TICK_W-1:0] stamp;
  } entry_t;

  typedef struct packed {
    logic due;
    logic better;
  } cmp_res_t;

endpackage

@@ rtl/sdtt_ram.sv @@
// sdtt_ram: generic single write port, single read port ram with registered read
// no package dependencies
module sdtt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/sdtt_cmp.sv @@
// sdtt_cmp: shared compare unit, checks one entry for expiry and orders it against the best
// depends on sdtt_pkg
module sdtt_cmp
  import sdtt_pkg::*;
(
  input  logic              armed_bit,
  input  entry_t            cand,
  input  entry_t            best,
  input  logic              found,
  input  logic [TICK_W-1:0] now,
  output cmp_res_t          res
);

  always_comb begin
    res.due    = armed_bit && (cand.deadline <= now);
    // ties on both keys keep the earlier (lower) index, which was seen first
    res.better = !found || ({cand.deadline, cand.stamp} < {best.deadline, best.stamp});
  end

endmodule

@@ rtl/sorted_deadline_timer_table.sv @@
// sorted_deadline_timer_table: top level, sequencer, armed bits and result register
// depends on sdtt_pkg, sdtt_ram, sdtt_cmp
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-------------------------------
//   in      | input     | in_valid / in_stall  | func, slot, interval, now
//   out     | output    | out_valid / out_stall| slot_out, status, expired, last
//
// insert, remove and update finish in the cycle they are accepted, reply in the next cycle
// a tick runs one scan pass per expired slot, or a single pass when nothing is due;
// each pass walks the entry ram at one slot per cycle, then goes through S_LAST and S_EMIT
// reset clears the armed bits and the stamp counter at once, no clearing pass is needed
// in_stall is high while a tick scan is running or a result waits behind out_stall
// a stalled result holds in the output register; the next expiry waits in S_EMIT until it is taken
module sorted_deadline_timer_table
  import sdtt_pkg::*;
#(
  parameter int TIMER_SLOTS = DEF_TIMER_SLOTS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          func,
  input  logic [SLOT_W-1:0]   slot,
  input  logic [TICK_W-1:0]   interval,
  input  logic [TICK_W-1:0]   now,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [SLOT_W-1:0]   slot_out,
  output logic [STATUS_W-1:0] status,
  output logic                expired,
  output logic                last
);

  localparam int SW = $clog2(TIMER_SLOTS);

  state_t state, state_next;

  logic [TIMER_SLOTS-1:0] armed;
  logic [TICK_W-1:0]      arm_counter;
  logic [TICK_W-1:0]      now_q;

  // scan bookkeeping
  logic [SW-1:0] cnt;
  logic          rd_pend;
  logic [SW-1:0] rd_idx;
  logic          found;
  logic          multi;
  entry_t        best;
  logic [SW-1:0] best_idx;

  // control
  logic    out_free;
  logic    in_acc;
  logic    rd_en;
  logic    emit_go;
  logic    scan_end;
  func_t   fn;
  logic    slot_ok;
  logic [SW-1:0] slot_idx;

  // ram side
  logic     ram_we;
  entry_t   ram_wdata;
  entry_t   ram_rdata;
  cmp_res_t res;

  assign fn       = func_t'(func);
  assign slot_ok  = (int'(slot) < TIMER_SLOTS);
  assign slot_idx = SW'(slot);
  assign out_free = !out_valid || !out_stall;
  assign in_acc   = in_valid && !in_stall;
  assign scan_end = (cnt == SW'(TIMER_SLOTS - 1));

  // an in-range insert of an idle slot and any in-range update write a fresh deadline and stamp
  assign ram_we = in_acc && slot_ok &&
                  ((fn == FN_INSERT && !armed[slot_idx]) || fn == FN_UPDATE);
  assign ram_wdata.deadline = now + interval;
  assign ram_wdata.stamp    = arm_counter;

  sdtt_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(TIMER_SLOTS)
  ) u_entries (
    .clk  (clk),
    .we   (ram_we),
    .waddr(slot_idx),
    .wdata(ram_wdata),
    .re   (rd_en),
    .raddr(cnt),
    .rdata(ram_rdata)
  );

  sdtt_cmp u_cmp (
    .armed_bit(armed[rd_idx]),
    .cand     (ram_rdata),
    .best     (best),
    .found    (found),
    .now      (now_q),
    .res      (res)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_acc && fn == FN_TICK) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_end) begin
          state_next = S_LAST;
        end
      end
      S_LAST: begin
        state_next = S_EMIT;
      end
      S_EMIT: begin
        priority if (!found) begin
          state_next = S_IDLE;
        end else if (out_free) begin
          state_next = multi ? S_SCAN : S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall = 1'b1;
    rd_en    = 1'b0;
    emit_go  = 1'b0;
    unique case (state)
      S_IDLE: in_stall = !out_free;
      S_SCAN: rd_en    = 1'b1;
      S_LAST: ;
      S_EMIT: emit_go  = found && out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      armed       <= '0;
      arm_counter <= '0;
      out_valid   <= 1'b0;
      found       <= 1'b0;
      multi       <= 1'b0;
      rd_pend     <= 1'b0;
      cnt         <= '0;
    end else begin
      state   <= state_next;
      rd_pend <= rd_en;
      rd_idx  <= cnt;

      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      if (rd_en) begin
        cnt <= scan_end ? '0 : cnt + 1'b1;
      end

      // fold one read entry into the running best; count past one due slot
      if (rd_pend && res.due) begin
        found <= 1'b1;
        multi <= found;
        if (res.better) begin
          best     <= ram_rdata;
          best_idx <= rd_idx;
        end
      end

      if (ram_we) begin
        arm_counter <= arm_counter + 1'b1;
      end

      if (in_acc) begin
        if (fn == FN_TICK) begin
          now_q <= now;
          found <= 1'b0;
          multi <= 1'b0;
          cnt   <= '0;
        end else begin
          out_valid <= 1'b1;
          slot_out  <= slot;
          expired   <= 1'b0;
          last      <= 1'b1;
          status    <= ST_OK;
          unique case (fn)
            FN_INSERT: begin
              if (slot_ok) begin
                if (armed[slot_idx]) begin
                  status <= ST_ARMED;
                end else begin
                  armed[slot_idx] <= 1'b1;
                end
              end
            end
            FN_REMOVE: begin
              if (slot_ok && armed[slot_idx]) begin
                armed[slot_idx] <= 1'b0;
              end else begin
                status <= ST_NOT_ARMED;
              end
            end
            FN_UPDATE: begin
              if (slot_ok) begin
                armed[slot_idx] <= 1'b1;
              end
            end
            default: ;
          endcase
        end
      end

      // earliest due slot goes out; last when it was the only one due this pass
      if (emit_go) begin
        out_valid       <= 1'b1;
        slot_out        <= SLOT_W'(best_idx);
        status          <= ST_OK;
        expired         <= 1'b1;
        last            <= !multi;
        armed[best_idx] <= 1'b0;
        found           <= 1'b0;
        multi           <= 1'b0;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    in_acc |-> state == S_IDLE)
    else $error("transaction accepted outside idle");

  a_reply_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !expired |-> last)
    else $error("operation reply without last");

  a_expiry_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && expired |-> status == ST_OK)
    else $error("expiry with non-ok status");

  a_emit_armed: assert property (@(posedge clk) disable iff (rst)
    emit_go |-> armed[best_idx])
    else $error("expiry of a slot that is not armed");

  a_emit_disarms: assert property (@(posedge clk) disable iff (rst)
    emit_go |=> !armed[$past(best_idx)])
    else $error("expired slot still armed");
`endif

endmodule

@@ tb/sv/tb_top.sv @@
// tb_top: self-checking testbench for sorted_deadline_timer_table
// depends on sdtt_pkg and the rtl top level; a queue-fed driver and a monitor check every reply
// and every expiry against an in-bench timer table model
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import sdtt_pkg::*;

  localparam int NSLOTS    = DEF_TIMER_SLOTS;
  localparam int LIMIT     = 600000;
  localparam int RAND_OPS  = 110;
  localparam int IDLE_PCT  = 16;

  // one input transaction as the driver presents it
  typedef struct {
    func_t              fn;
    logic [SLOT_W-1:0]  slot;
    logic [TICK_W-1:0]  ival;
    logic [TICK_W-1:0]  tnow;
    bit                 hold;   // wait for every pending reply before sending
  } timer_op_t;

  // one output transaction as the table should produce it
  typedef struct {
    logic [SLOT_W-1:0]  slot_out;
    status_t            status;
    logic               expired;
    logic               last;
  } timer_result_t;

  logic                clk;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [1:0]          func = '0;
  logic [SLOT_W-1:0]   slot = '0;
  logic [TICK_W-1:0]   interval = '0;
  logic [TICK_W-1:0]   now = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [SLOT_W-1:0]   slot_out;
  logic [STATUS_W-1:0] status;
  logic                expired;
  logic                last;

  sorted_deadline_timer_table #(
    .TIMER_SLOTS(NSLOTS)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .func     (func),
    .slot     (slot),
    .interval (interval),
    .now      (now),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .slot_out (slot_out),
    .status   (status),
    .expired  (expired),
    .last     (last)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // transactions waiting to be driven, and replies/expiries still owed by the table
  timer_op_t     pending_ops[$];
  timer_result_t due_results[$];
  timer_op_t     cur_op;
  int            ops_total    = 0;
  int            ops_accepted = 0;
  int            mismatches   = 0;
  int            cycle_count  = 0;

  // bench copy of the timer table, advanced only on accepted transactions
  logic              slot_armed[NSLOTS];
  logic [TICK_W-1:0] slot_deadline[NSLOTS];
  logic [TICK_W-1:0] slot_stamp[NSLOTS];
  logic [TICK_W-1:0] stamp_next = '0;

  // rough view of which slots are armed, used only to shape the stimulus
  logic              plan_armed[NSLOTS];
  logic [TICK_W-1:0] plan_deadline[NSLOTS];

  // long windows with no idling on either side, idle at random elsewhere
  wire calm = ((cycle_count / 1000) % 3) == 1;

  initial begin
    for (int i = 0; i < NSLOTS; i++) begin
      slot_armed[i] = 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // timer table model
  // ---------------------------------------------------------------------------

  // arm a slot: deadline wraps mod 2^32, stamp records arming order
  function automatic void arm_timer(int s, logic [TICK_W-1:0] tnow, logic [TICK_W-1:0] ival);
    slot_armed[s]    = 1'b1;
    slot_deadline[s] = tnow + ival;
    slot_stamp[s]    = stamp_next;
    stamp_next       = stamp_next + 1;
  endfunction

  // earliest due slot: lowest deadline, then oldest stamp, then lowest index; -1 if none
  function automatic int earliest_due(logic [TICK_W-1:0] tnow);
    int best;
    best = -1;
    for (int i = 0; i < NSLOTS; i++) begin
      if (slot_armed[i] && slot_deadline[i] <= tnow) begin
        if (best < 0 || slot_deadline[i] < slot_deadline[best] ||
            (slot_deadline[i] == slot_deadline[best] && slot_stamp[i] < slot_stamp[best]))
          best = i;
      end
    end
    return best;
  endfunction

  // apply one accepted transaction and queue the results it owes
  function automatic void timer_table_apply(timer_op_t op);
    int            best;
    int            fired;
    bit            in_range;
    timer_result_t res;
    in_range     = (int'(op.slot) < NSLOTS);
    res.slot_out = op.slot;
    res.status   = ST_OK;
    res.expired  = 1'b0;
    res.last     = 1'b1;
    if (op.fn == FN_TICK) begin
      // expiries come out one by one in deadline order, last marks the final one
      fired = 0;
      best  = earliest_due(op.tnow);
      while (best >= 0 && fired < 32) begin
        slot_armed[best] = 1'b0;
        res.slot_out     = best[SLOT_W-1:0];
        res.status       = ST_OK;
        res.expired      = 1'b1;
        res.last         = 1'b0;
        due_results.push_back(res);
        fired++;
        best = earliest_due(op.tnow);
      end
      if (fired > 0)
        due_results[due_results.size()-1].last = 1'b1;
    end else begin
      case (op.fn)
        FN_INSERT: begin
          if (in_range) begin
            if (slot_armed[op.slot])
              res.status = ST_ARMED;
            else
              arm_timer(op.slot, op.tnow, op.ival);
          end
        end
        FN_REMOVE: begin
          if (in_range && slot_armed[op.slot])
            slot_armed[op.slot] = 1'b0;
          else
            res.status = ST_NOT_ARMED;
        end
        default: begin
          // update re-arms with a fresh stamp, armed or not
          if (in_range)
            arm_timer(op.slot, op.tnow, op.ival);
        end
      endcase
      due_results.push_back(res);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus generation
  // ---------------------------------------------------------------------------

  function automatic void queue_op(func_t fn, int s, logic [TICK_W-1:0] ival,
                                   logic [TICK_W-1:0] tnow, bit hold);
    timer_op_t op;
    op.fn   = fn;
    op.slot = s[SLOT_W-1:0];
    op.ival = ival;
    op.tnow = tnow;
    op.hold = hold;
    pending_ops.push_back(op);
    ops_total++;
    if (s < NSLOTS) begin
      case (fn)
        FN_INSERT: begin
          if (!plan_armed[s]) begin
            plan_armed[s]    = 1'b1;
            plan_deadline[s] = tnow + ival;
          end
        end
        FN_REMOVE: plan_armed[s] = 1'b0;
        FN_UPDATE: begin
          plan_armed[s]    = 1'b1;
          plan_deadline[s] = tnow + ival;
        end
        default: ;
      endcase
    end
    if (fn == FN_TICK) begin
      for (int i = 0; i < NSLOTS; i++)
        if (plan_deadline[i] <= tnow)
          plan_armed[i] = 1'b0;
    end
  endfunction

  // a slot in the wanted state if one exists, else any slot
  function automatic int pick_slot(bit want_armed);
    int start;
    int s;
    start = $urandom_range(NSLOTS-1);
    for (int k = 0; k < NSLOTS; k++) begin
      s = (start + k) % NSLOTS;
      if (plan_armed[s] == want_armed)
        return s;
    end
    return start;
  endfunction

  // mostly short intervals so ticks find work, now and then a full-range one
  function automatic logic [TICK_W-1:0] short_interval();
    if ($urandom_range(9) == 0)
      return $urandom;
    return $urandom_range(30);
  endfunction

  function automatic void build_stimulus();
    int                n_rand;
    int                bursts;
    int                roll;
    bit                hold_next;
    bit                mid_hold_done;
    logic [TICK_W-1:0] plan_now;
    n_rand        = 0;
    bursts        = 0;
    hold_next     = 1'b1;
    mid_hold_done = 1'b0;
    plan_now      = 32'd1000;
    for (int i = 0; i < NSLOTS; i++)
      plan_armed[i] = 1'b0;

    // directed: zero and full-range fields, wrap of the deadline sum, every reply status
    queue_op(FN_INSERT, 0, 32'd0, 32'd0, 1'b0);
    queue_op(FN_INSERT, NSLOTS-1, 32'hFFFF_FFFF, 32'd1, 1'b0);  // wraps to deadline 0
    queue_op(FN_INSERT, 0, 32'd5, 32'd2, 1'b0);                 // already armed
    queue_op(FN_REMOVE, 5, 32'd0, 32'd2, 1'b0);                 // not armed
    queue_op(FN_TICK, 0, 32'd0, 32'd0, 1'b0);                   // equal deadlines, stamp order
    queue_op(FN_TICK, 0, 32'd0, 32'hFFFF_FFFF, 1'b0);           // nothing due
    queue_op(FN_INSERT, 3, 32'd10, 32'd100, 1'b0);
    queue_op(FN_INSERT, 4, 32'd5, 32'd105, 1'b0);
    queue_op(FN_UPDATE, 3, 32'd10, 32'd100, 1'b0);              // re-arm goes behind slot 4
    queue_op(FN_INSERT, 7, 32'd2, 32'd100, 1'b0);
    queue_op(FN_REMOVE, 7, 32'd0, 32'd100, 1'b0);
    queue_op(FN_REMOVE, 7, 32'd0, 32'd100, 1'b0);
    queue_op(FN_UPDATE, 9, 32'd0, 32'd109, 1'b0);               // update of an idle slot
    queue_op(FN_TICK, 0, 32'd0, 32'd109, 1'b0);
    queue_op(FN_TICK, 0, 32'd0, 32'd110, 1'b0);
    queue_op(FN_INSERT, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    queue_op(FN_UPDATE, 2, 32'd0, 32'hFFFF_FFFF, 1'b0);
    queue_op(FN_TICK, 0, 32'd0, 32'hFFFF_FFFE, 1'b0);
    queue_op(FN_TICK, 0, 32'd0, 32'hFFFF_FFFF, 1'b0);
    queue_op(FN_REMOVE, NSLOTS-1, 32'd0, 32'hFFFF_FFFF, 1'b0);

    // random: mostly coherent traffic on a forward running clock, some noise,
    // and a couple of bursts that arm every slot and expire them all at once
    while (n_rand < RAND_OPS) begin
      if (n_rand >= RAND_OPS / 2 && !mid_hold_done) begin
        hold_next     = 1'b1;
        mid_hold_done = 1'b1;
      end
      roll = $urandom_range(99);
      if (roll < 4 && bursts < 2) begin
        for (int s = 0; s < NSLOTS; s++) begin
          queue_op(FN_UPDATE, s, $urandom_range(7), plan_now, hold_next);
          hold_next = 1'b0;
        end
        plan_now = plan_now + 7;
        queue_op(FN_TICK, $urandom_range(NSLOTS-1), $urandom, plan_now, 1'b0);
        bursts++;
        n_rand += NSLOTS + 1;
      end else if (roll < 18) begin
        queue_op(func_t'($urandom_range(3)), $urandom_range(NSLOTS-1), $urandom, $urandom,
                 hold_next);
        n_rand++;
      end else begin
        plan_now = plan_now + $urandom_range(6);
        roll     = $urandom_range(99);
        if (roll < 30)
          queue_op(FN_INSERT, pick_slot(1'b0), short_interval(), plan_now, hold_next);
        else if (roll < 45)
          queue_op(FN_REMOVE, pick_slot(1'b1), $urandom, plan_now, hold_next);
        else if (roll < 60)
          queue_op(FN_UPDATE, $urandom_range(NSLOTS-1), short_interval(), plan_now, hold_next);
        else
          queue_op(FN_TICK, $urandom_range(NSLOTS-1), $urandom, plan_now, hold_next);
        n_rand++;
      end
      hold_next = 1'b0;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // driver: presents one transaction at a time, holds it steady while stalled
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        timer_table_apply(cur_op);
        ops_accepted++;
      end
      if (!in_valid || !in_stall) begin
        // free to move on: idle at random, or wait for the table to drain on a hold
        if (pending_ops.size() == 0 || (!calm && $urandom_range(99) < IDLE_PCT) ||
            (pending_ops[0].hold && due_results.size() != 0)) begin
          in_valid <= 1'b0;
        end else begin
          cur_op = pending_ops.pop_front();
          in_valid <= 1'b1;
          func     <= cur_op.fn;
          slot     <= cur_op.slot;
          interval <= cur_op.ival;
          now      <= cur_op.tnow;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: stalls at random, checks each accepted result against the oldest owed one
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    timer_result_t want;
    bit            bad;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          $display("%0t: unexpected result, actual slot_out %0d status %0d expired %0b last %0b",
                   $time, slot_out, status, expired, last);
          mismatches++;
        end else begin
          want = due_results.pop_front();
          bad  = 1'b0;
          if (slot_out !== want.slot_out) begin
            $display("%0t: slot_out expected %0d actual %0d", $time, want.slot_out, slot_out);
            bad = 1'b1;
          end
          if (status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, status);
            bad = 1'b1;
          end
          if (expired !== want.expired) begin
            $display("%0t: expired expected %0b actual %0b", $time, want.expired, expired);
            bad = 1'b1;
          end
          if (last !== want.last) begin
            $display("%0t: last expected %0b actual %0b", $time, want.last, last);
            bad = 1'b1;
          end
          if (bad)
            mismatches++;
        end
      end
      out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // watchdog, sized well past the slowest legal run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, due_results.size());
      $display("** sorted_deadline_timer_table: FAILED **");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // run control
  // ---------------------------------------------------------------------------
  initial begin
    build_stimulus();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    while (ops_accepted != ops_total)
      @(posedge clk);
    while (due_results.size() != 0)
      @(posedge clk);
    // a final tick may still be scanning with nothing to report
    repeat (4 * (NSLOTS + 2)) @(posedge clk);
    if (mismatches == 0 && due_results.size() == 0)
      $display("** sorted_deadline_timer_table: PASSED **");
    else
      $display("** sorted_deadline_timer_table: FAILED **");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/sdtt_pkg.sv
rtl/sdtt_ram.sv
rtl/sdtt_cmp.sv
rtl/sorted_deadline_timer_table.sv
tb/sv/tb_top.sv
